/* rtl/dtte_pkg.sv */
package dtte_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       null_value;
    } t_in;

    typedef struct packed {
        logic signed [63:0] value;
        logic               is_null;
        logic               status;
    } t_out;

    typedef struct packed {
        logic             is_null;
        logic             err;
        logic [1:0]       kind;
        logic [1:0]       unit;
        logic             neg;
        logic [5:0][31:0] f;
        logic [31:0]      frac;
        logic [3:0]       fdig;
    } t_job;

    localparam logic [1:0] KIND_DATE  = 2'd0;
    localparam logic [1:0] KIND_TIME  = 2'd1;
    localparam logic [1:0] KIND_STAMP = 2'd2;
    localparam logic [1:0] KIND_ALT   = 2'd3;

    localparam logic [1:0] UNIT_BASE = 2'd0;

    localparam logic CFG_KIND = 1'b0;
    localparam logic CFG_UNIT = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    localparam int EPOCH_JDAY    = 2440588;
    localparam int JD_BIAS       = 32167;
    localparam int YEAR_OFF_HI   = 4800;
    localparam int YEAR_OFF_LO   = 4799;
    localparam int MONTH_MUL     = 7834;
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int MS_PER_DAY    = 86400000;

    localparam logic [31:0] RECIP_10  = 32'hCCCCCCCD;
    localparam logic [31:0] RECIP_100 = 32'h51EB851F;

    function automatic logic [29:0] pow10(input logic [3:0] e);
        logic [29:0] p;
        unique case (e)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

/* rtl/dtte_front.sv */
module dtte_front import dtte_pkg::*; #(
    parameter int FRAC_MAX_DIGITS = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_in        i_in,
    input  logic [1:0] i_kind,
    input  logic [1:0] i_unit,
    output logic       o_job_valid,
    output t_job       o_job
);

    localparam logic [3:0] FD_MAX = 4'(FRAC_MAX_DIGITS);
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    logic [2:0]       r_slot, n_slot;
    logic [6:0][31:0] r_fv, n_fv;
    logic [3:0]       r_dc, n_dc;
    logic [3:0]       r_fd, n_fd;
    logic             r_neg, n_neg;
    logic             r_err, n_err;

    logic [1:0]  k;
    logic [2:0]  ni;
    logic        in_frac;
    logic [7:0]  c;
    logic        is_digit;
    logic [3:0]  limit;
    logic        sep_ok;
    logic [7:0]  sep_ch;
    logic [31:0] cur;
    logic [31:0] acc;
    logic        has_frac;
    logic        ok;

    assign k        = (i_kind == KIND_ALT) ? KIND_STAMP : i_kind;
    assign ni       = (k == KIND_STAMP) ? 3'd6 : 3'd3;
    assign in_frac  = (r_slot == ni);
    assign c        = i_in.char_code;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign cur      = r_fv[r_slot];
    assign acc      = (cur << 3) + (cur << 1) + {28'd0, c[3:0]};

    always_comb begin
        limit = 4'd9;
        if (k == KIND_STAMP) begin
            if (r_slot == 3'd0) begin
                limit = r_neg ? 4'd3 : 4'd4;
            end else if (r_slot <= 3'd2) begin
                limit = 4'd2;
            end
        end
    end

    always_comb begin
        sep_ok = 1'b0;
        sep_ch = CH_MINUS;
        if (k == KIND_STAMP) begin
            sep_ok = (r_slot < 3'd6);
            unique case (r_slot)
                3'd0, 3'd1: sep_ch = CH_MINUS;
                3'd2:       sep_ch = CH_SPACE;
                3'd3, 3'd4: sep_ch = CH_COLON;
                default:    sep_ch = CH_DOT;
            endcase
        end else if (k == KIND_TIME) begin
            sep_ok = (r_slot < 3'd3);
            sep_ch = (r_slot == 3'd2) ? CH_DOT : CH_COLON;
        end else begin
            sep_ok = (r_slot < 3'd2);
            sep_ch = CH_MINUS;
        end
    end

    always_comb begin
        n_slot = r_slot;
        n_fv   = r_fv;
        n_dc   = r_dc;
        n_fd   = r_fd;
        n_neg  = r_neg;
        n_err  = r_err;
        if (!r_err) begin
            if ((r_slot > ni) || (in_frac && (k == KIND_DATE))) begin
                n_err = 1'b1;
            end else if (is_digit) begin
                if (in_frac) begin
                    if ((k == KIND_TIME) && (r_fd >= 4'd6)) begin
                        n_err = 1'b1;
                    end else if (r_fd < FD_MAX) begin
                        n_fv[r_slot] = acc;
                        n_fd         = r_fd + 4'd1;
                    end
                end else if (r_dc >= limit) begin
                    n_err = 1'b1;
                end else begin
                    n_fv[r_slot] = acc;
                    n_dc         = r_dc + 4'd1;
                end
            end else if ((c == CH_MINUS) && (r_slot == 3'd0) && (r_dc == 4'd0) && !r_neg) begin
                n_neg = 1'b1;
            end else if (!in_frac && (r_dc != 4'd0) && sep_ok && (c == sep_ch)) begin
                n_slot = r_slot + 3'd1;
                n_dc   = 4'd0;
            end else begin
                n_err = 1'b1;
            end
        end
    end

    assign has_frac = (n_slot == ni) && (k != KIND_DATE) && (n_fd != 4'd0);
    assign ok = !n_err &&
                ((({1'b0, n_slot} + 4'd1 == {1'b0, ni}) && (n_dc != 4'd0)) || has_frac);

    assign o_job_valid = i_take && (i_in.null_value || i_in.last_char);

    always_comb begin
        o_job.is_null = i_in.null_value;
        o_job.err     = !i_in.null_value && !ok;
        o_job.kind    = k;
        o_job.unit    = i_unit;
        o_job.neg     = n_neg;
        for (int j = 0; j < 6; j++) begin
            o_job.f[j] = n_fv[j];
        end
        o_job.frac = has_frac ? n_fv[ni] : 32'd0;
        o_job.fdig = has_frac ? n_fd : 4'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_fv   <= '0;
            r_dc   <= '0;
            r_fd   <= '0;
            r_neg  <= 1'b0;
            r_err  <= 1'b0;
        end else if (i_take) begin
            if (i_in.null_value || i_in.last_char) begin
                r_slot <= '0;
                r_fv   <= '0;
                r_dc   <= '0;
                r_fd   <= '0;
                r_neg  <= 1'b0;
                r_err  <= 1'b0;
            end else begin
                r_slot <= n_slot;
                r_fv   <= n_fv;
                r_dc   <= n_dc;
                r_fd   <= n_fd;
                r_neg  <= n_neg;
                r_err  <= n_err;
            end
        end
    end

endmodule

/* rtl/dtte_queue.sv */
module dtte_queue import dtte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("A transaction was offered to a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("A transaction was taken from an empty queue.");

endmodule

/* rtl/dtte_back.sv */
module dtte_back import dtte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_take,
    input  logic i_pop,
    output logic o_empty,
    output t_out o_out
);

    typedef enum logic [16:0] {
        ST_IDLE = 17'h00001,
        ST_FDIV = 17'h00002,
        ST_FMUL = 17'h00004,
        ST_PREP = 17'h00008,
        ST_CENT = 17'h00010,
        ST_MT   = 17'h00020,
        ST_Y365 = 17'h00040,
        ST_JD1  = 17'h00080,
        ST_JD2  = 17'h00100,
        ST_DMS  = 17'h00200,
        ST_SA   = 17'h00400,
        ST_SB   = 17'h00800,
        ST_SC   = 17'h01000,
        ST_P0   = 17'h02000,
        ST_P1   = 17'h04000,
        ST_P2   = 17'h08000,
        ST_DONE = 17'h10000
    } t_state;

    function automatic logic [63:0] sext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    t_state             r_state;
    t_job               r_job;
    logic [31:0]        r_frac;
    logic [3:0]         r_cnt;
    logic signed [33:0] r_y;
    logic [31:0]        r_ay;
    logic [31:0]        r_mm;
    logic [31:0]        r_cent;
    logic [36:0]        r_mterm;
    logic signed [43:0] r_y365;
    logic [47:0]        r_jd;
    logic [47:0]        r_days;
    logic [63:0]        r_t0, r_t1, r_secs, r_plo, r_res;
    logic [31:0]        r_phi;
    logic               r_ov;
    t_out               r_out;

    logic [3:0]         isc, sc;
    logic [29:0]        p_sc;
    logic signed [33:0] first;
    logic               m_gt2;
    logic signed [33:0] y_c;
    logic [63:0]        div_prod;
    logic [61:0]        fmul_prod;
    logic [63:0]        cent_prod;
    logic [44:0]        mt_prod;
    logic               ysgn;
    logic [47:0]        y365_w, y4_s, cent_s, cent4_s;
    logic signed [75:0] dms_prod;
    logic signed [65:0] sa_prod;
    logic signed [33:0] sb_op;
    logic signed [46:0] sb_prod;
    logic [31:0]        c_op, d_op;
    logic [63:0]        c60;
    logic [61:0]        lo_prod, hi_prod;
    logic [63:0]        p2_sum;
    logic               stamp;
    logic               out_free;

    assign isc   = {2'b00, i_job.unit} + {1'b0, i_job.unit, 1'b0};
    assign sc    = {2'b00, r_job.unit} + {1'b0, r_job.unit, 1'b0};
    assign p_sc  = pow10(sc);
    assign stamp = (r_job.kind == KIND_STAMP);
    assign first = r_job.neg ? -$signed({2'b00, r_job.f[0]}) : $signed({2'b00, r_job.f[0]});
    assign m_gt2 = (r_job.f[1] > 32'd2);
    assign y_c   = first + (m_gt2 ? 34'(YEAR_OFF_HI) : 34'(YEAR_OFF_LO));

    assign div_prod  = {32'd0, r_frac} * {32'd0, RECIP_10};
    assign fmul_prod = {30'd0, r_frac} * {32'd0, pow10(r_cnt)};
    assign cent_prod = {32'd0, r_ay} * {32'd0, RECIP_100};
    assign mt_prod   = {13'd0, r_mm} * 45'(MONTH_MUL);

    assign ysgn    = r_y[33];
    assign y365_w  = {{4{r_y365[43]}}, r_y365};
    assign y4_s    = ysgn ? -{16'd0, (r_ay >> 2)} : {16'd0, (r_ay >> 2)};
    assign cent_s  = ysgn ? -{16'd0, r_cent} : {16'd0, r_cent};
    assign cent4_s = ysgn ? -{16'd0, (r_cent >> 2)} : {16'd0, (r_cent >> 2)};

    assign dms_prod = $signed(r_days) * $signed(28'(MS_PER_DAY));
    assign sa_prod  = $signed(r_days) * $signed(18'(SECS_PER_DAY));
    assign sb_op    = stamp ? $signed({2'b00, r_job.f[3]}) : first;
    assign sb_prod  = sb_op * $signed(13'(SECS_PER_HOUR));
    assign c_op     = stamp ? r_job.f[4] : r_job.f[1];
    assign d_op     = stamp ? r_job.f[5] : r_job.f[2];
    assign c60      = {26'd0, c_op, 6'd0} - {30'd0, c_op, 2'd0};
    assign lo_prod  = {30'd0, r_secs[31:0]} * {32'd0, p_sc};
    assign hi_prod  = {30'd0, r_secs[63:32]} * {32'd0, p_sc};
    assign p2_sum   = r_plo + {r_phi, 32'd0} + {32'd0, r_frac};

    assign out_free   = !r_ov || i_pop;
    assign o_job_take = (r_state == ST_IDLE) && i_job_valid;
    assign o_empty    = !r_ov;
    assign o_out      = r_out;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_job  <= i_job;
                r_frac <= i_job.frac;
                r_res  <= '0;
                r_cnt  <= (i_job.fdig > isc) ? (i_job.fdig - isc) : (isc - i_job.fdig);
            end
            ST_FDIV: begin
                r_frac <= div_prod[63:32] >> 3;
                r_cnt  <= r_cnt - 4'd1;
            end
            ST_FMUL: r_frac <= fmul_prod[31:0];
            ST_PREP: begin
                r_y  <= y_c;
                r_ay <= y_c[33] ? 32'(-y_c) : 32'(y_c);
                r_mm <= m_gt2 ? (r_job.f[1] + 32'd1) : (r_job.f[1] + 32'd13);
            end
            ST_CENT: r_cent  <= cent_prod[63:37] == '0 ? 32'd0 : 32'(cent_prod[63:37]);
            ST_MT:   r_mterm <= mt_prod[44:8];
            ST_Y365: r_y365  <= 44'(r_y) * 44'sd365;
            ST_JD1:  r_jd    <= y365_w + y4_s - cent_s + cent4_s;
            ST_JD2: begin
                r_days <= r_jd + {11'd0, r_mterm} + {16'd0, r_job.f[2]}
                        - 48'(JD_BIAS + EPOCH_JDAY);
                r_res  <= sext32(64'(r_jd + {11'd0, r_mterm} + {16'd0, r_job.f[2]}
                        - 48'(JD_BIAS + EPOCH_JDAY)));
            end
            ST_DMS:  r_res  <= dms_prod[63:0];
            ST_SA:   r_t0   <= stamp ? sa_prod[63:0] : 64'd0;
            ST_SB:   r_t1   <= {{17{sb_prod[46]}}, sb_prod};
            ST_SC:   r_secs <= r_t0 + r_t1 + c60 + {32'd0, d_op};
            ST_P0:   r_plo  <= {2'b00, lo_prod};
            ST_P1:   r_phi  <= hi_prod[31:0];
            ST_P2: begin
                r_res <= ((r_job.kind == KIND_TIME) && !r_job.unit[1]) ? sext32(p2_sum) : p2_sum;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out.value   <= $signed(r_res);
                    r_out.is_null <= r_job.is_null;
                    r_out.status  <= r_job.err;
                end
            end
            default: r_res <= r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if ((r_state == ST_DONE) && out_free) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        if (i_job.is_null || i_job.err) begin
                            r_state <= ST_DONE;
                        end else if (i_job.fdig > isc) begin
                            r_state <= ST_FDIV;
                        end else begin
                            r_state <= ST_FMUL;
                        end
                    end
                end
                ST_FDIV: begin
                    if (r_cnt == 4'd1) begin
                        r_state <= (r_job.kind == KIND_TIME) ? ST_SA : ST_PREP;
                    end
                end
                ST_FMUL: r_state <= (r_job.kind == KIND_TIME) ? ST_SA : ST_PREP;
                ST_PREP: r_state <= ST_CENT;
                ST_CENT: r_state <= ST_MT;
                ST_MT:   r_state <= ST_Y365;
                ST_Y365: r_state <= ST_JD1;
                ST_JD1:  r_state <= ST_JD2;
                ST_JD2: begin
                    if (r_job.kind == KIND_DATE) begin
                        r_state <= (r_job.unit == UNIT_BASE) ? ST_DONE : ST_DMS;
                    end else begin
                        r_state <= ST_SA;
                    end
                end
                ST_DMS:  r_state <= ST_DONE;
                ST_SA:   r_state <= ST_SB;
                ST_SB:   r_state <= ST_SC;
                ST_SC:   r_state <= ST_P0;
                ST_P0:   r_state <= ST_P1;
                ST_P1:   r_state <= ST_P2;
                ST_P2:   r_state <= ST_DONE;
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_null_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.is_null |-> (r_out.value == 64'sd0) && !r_out.status)
        else $error("A null result carries a value or an error.");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.status |-> (r_out.value == 64'sd0) && !r_out.is_null)
        else $error("A malformed result carries a value.");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FDIV) |-> (r_cnt != 4'd0))
        else $error("Fraction scaling entered with no digits to drop.");

endmodule

/* rtl/datetime_text_to_epoch_units_unit.sv */
// Converts date, time-of-day and timestamp text, one character per transaction, into an
// epoch-relative count. The input side accepts one character every cycle while its queue has
// room; each completed value then passes through the shared arithmetic sequencer (null or
// malformed values skip straight to its result state), which handles one value at a time. A
// two-entry queue between the character parser and the sequencer, and a result register in
// front of the output, let either side stall on its own.
module datetime_text_to_epoch_units_unit import dtte_pkg::*; #(
    parameter int FRAC_MAX_DIGITS = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_in        i_in_data,
    output logic       empty,
    input  logic       pop,
    output t_out       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [1:0] i_cfg_data
);

    logic [1:0] r_kind;
    logic [1:0] r_unit;
    logic       take;
    logic       job_valid;
    t_job       job_in;
    t_job       job_out;
    logic       q_empty;
    logic       job_take;

    assign o_cfg_ready = 1'b1;
    assign take        = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_STAMP;
            r_unit <= UNIT_BASE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KIND: r_kind <= i_cfg_data;
                CFG_UNIT: r_unit <= i_cfg_data;
                default:  r_unit <= r_unit;
            endcase
        end
    end

    dtte_front #(
        .FRAC_MAX_DIGITS(FRAC_MAX_DIGITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_in       (i_in_data),
        .i_kind     (r_kind),
        .i_unit     (r_unit),
        .o_job_valid(job_valid),
        .o_job      (job_in)
    );

    dtte_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_valid),
        .i_data (job_in),
        .i_pop  (job_take),
        .o_full (full),
        .o_empty(q_empty),
        .o_data (job_out)
    );

    dtte_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(!q_empty),
        .i_job      (job_out),
        .o_job_take (job_take),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out      (o_out_data)
    );

endmodule
